### rtl/sewg_pkg.sv
// ----------------------------------------------------------------------------
// sewg_pkg
// Shared constants and transaction tag types for the sparse edge weight
// gradient core: stream field positions, default sizes, pipeline tags.
// ----------------------------------------------------------------------------
package sewg_pkg;

  // default sizes
  localparam int NUM_BASIS_DEF = 4;
  localparam int NUM_TYPES_DEF = 256;
  localparam int EDGE_BITS_DEF = 20;
  localparam int LANES_MAX     = 4;

  // field widths
  localparam int EDGE_W = 20;
  localparam int TYPE_W = 8;
  localparam int REC_W  = 2;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int WG_W   = 32;

  // input tdata layout, lowest bit first
  localparam int IN_TDATA_W = 128;
  localparam int EDGE_LSB   = 0;
  localparam int TYPE_LSB   = 20;
  localparam int REC_LSB    = 28;
  localparam int BASIS_LSB  = 30;
  localparam int GRAD_LSB   = 46;
  localparam int ACT_LSB    = 110;

  // output tdata layout
  localparam int OUT_TDATA_W = 56;

  // item kinds carried on in_tuser
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // sample tag travelling alongside the lane pipeline
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [EDGE_W-1:0]       edge_idx;
    logic signed [VAL_W-1:0] act;
    logic                    type_ok;
    logic                    psat;
  } tag_t;

  // finished edge sum handed to the output stage
  typedef struct packed {
    logic                    valid;
    logic [EDGE_W-1:0]       edge_idx;
    logic signed [ACC_W-1:0] acc;
    logic                    sat;
  } fin_t;

endpackage

### rtl/sewg_lane.sv
// ----------------------------------------------------------------------------
// sewg_lane
// One projection lane: holds one basis column for all synapse types and
// multiplies the registered coefficient by the lane's upstream gradient.
// ----------------------------------------------------------------------------
module sewg_lane #(
  parameter int NUM_TYPES = sewg_pkg::NUM_TYPES_DEF,
  parameter int TYPE_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 wr_en,
  input  logic [TYPE_BITS-1:0]                 addr,
  input  logic signed [sewg_pkg::VAL_W-1:0]    wdata,
  input  logic signed [sewg_pkg::VAL_W-1:0]    grad,
  input  logic                                 ok,
  output logic signed [sewg_pkg::PROD_W-1:0]   prod
);

  logic signed [sewg_pkg::VAL_W-1:0]  mem_r [NUM_TYPES];
  logic signed [sewg_pkg::VAL_W-1:0]  b_r;
  logic signed [sewg_pkg::VAL_W-1:0]  g_r;
  logic signed [sewg_pkg::VAL_W-1:0]  bsel;
  logic signed [sewg_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en && wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= mem_r[addr];
      g_r <= grad;
    end
  end

  // out-of-range type projects onto an all-zero row
  assign bsel = ok ? b_r : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= g_r * bsel;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/sewg_merge.sv
// ----------------------------------------------------------------------------
// sewg_merge
// Combines the lane products: Q.12 rounding and 24-bit clamp of the
// projection, scaling by activity, saturating 48-bit batch accumulation.
// ----------------------------------------------------------------------------
module sewg_merge #(
  parameter int NUM_LANES = sewg_pkg::LANES_MAX
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic signed [sewg_pkg::PROD_W-1:0] prod [NUM_LANES],
  input  sewg_pkg::tag_t                     tag_in,
  output sewg_pkg::fin_t                     fin
);

  localparam int DOT_W  = sewg_pkg::PROD_W + 3;
  localparam int PROJ_W = 24;
  localparam int TERM_W = PROJ_W + sewg_pkg::VAL_W;
  localparam int SUM_W  = sewg_pkg::ACC_W + 1;
  localparam logic signed [DOT_W-1:0] PROJ_MAX = DOT_W'(signed'(64'sd8388607));
  localparam logic signed [DOT_W-1:0] PROJ_MIN = DOT_W'(signed'(-64'sd8388608));

  logic signed [DOT_W-1:0]            dot;
  logic signed [DOT_W-1:0]            dot_rnd;
  logic signed [DOT_W-1:0]            dot_q;
  logic signed [PROJ_W-1:0]           proj_nxt;
  logic                               psat_nxt;
  logic signed [PROJ_W-1:0]           proj_r;
  sewg_pkg::tag_t                     tag3_nxt;
  sewg_pkg::tag_t                     tag3_r;
  logic signed [TERM_W-1:0]           term_r;
  sewg_pkg::tag_t                     tag4_r;
  logic signed [SUM_W-1:0]            sum;
  logic signed [sewg_pkg::ACC_W-1:0]  acc_nxt;
  logic                               sat_nxt;
  logic signed [sewg_pkg::ACC_W-1:0]  acc_r;
  logic                               sat_r;
  sewg_pkg::fin_t                     fin_nxt;
  sewg_pkg::fin_t                     fin_r;

  // lane sum, round half up to Q.12, clamp to 24 bits
  always_comb begin
    dot = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      dot = dot + DOT_W'(prod[i]);
    end
    dot_rnd = dot + DOT_W'(signed'(64'sd2048));
    dot_q   = dot_rnd >>> 12;
    psat_nxt = 1'b0;
    if (dot_q > PROJ_MAX) begin
      proj_nxt = {1'b0, {(PROJ_W-1){1'b1}}};
      psat_nxt = 1'b1;
    end else if (dot_q < PROJ_MIN) begin
      proj_nxt = {1'b1, {(PROJ_W-1){1'b0}}};
      psat_nxt = 1'b1;
    end else begin
      proj_nxt = dot_q[PROJ_W-1:0];
    end
  end

  always_comb begin
    tag3_nxt      = tag_in;
    tag3_nxt.psat = psat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag3_r <= tag3_nxt;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_r <= proj_nxt;
      term_r <= proj_r * tag3_r.act;
    end
  end

  // saturating accumulate: overflow shows as a mismatch of the top two bits
  always_comb begin
    sum     = SUM_W'(acc_r) + SUM_W'(term_r);
    sat_nxt = sat_r | tag4_r.psat;
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      acc_nxt = sum[SUM_W-1] ? {1'b1, {(sewg_pkg::ACC_W-1){1'b0}}}
                             : {1'b0, {(sewg_pkg::ACC_W-1){1'b1}}};
      sat_nxt = 1'b1;
    end else begin
      acc_nxt = sum[sewg_pkg::ACC_W-1:0];
    end
  end

  always_comb begin
    fin_nxt.valid    = tag4_r.valid && tag4_r.last;
    fin_nxt.edge_idx = tag4_r.edge_idx;
    fin_nxt.acc      = acc_nxt;
    fin_nxt.sat      = sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
      fin_r <= '0;
    end else if (en) begin
      fin_r <= fin_nxt;
      if (tag4_r.valid) begin
        if (tag4_r.last) begin
          acc_r <= '0;
          sat_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          sat_r <= sat_nxt;
        end
      end
    end
  end

  assign fin = fin_r;

endmodule

### rtl/sparse_edge_weight_gradient_core.sv
// ----------------------------------------------------------------------------
// sparse_edge_weight_gradient_core
// Per-edge weight gradient over a streamed batch: basis table loads and
// sample projection across parallel lanes, accumulation, Q.12 result.
//
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata: fields below, tuser: kind,
//                                     tlast: last sample of the edge
// out_     out  out_tvalid/out_tready tdata: edge_out, grad_total,
//                                     tuser: saturated
//
// One item per cycle while the pipeline is not held; out_tvalid rises
// once the last sample of an edge has passed every stage. The pipeline
// is lane read/multiply (2), projection round, activity multiply,
// accumulate, output round; the accumulator loop closes through acc_r.
// The whole pipeline holds while a result waits in the output register.
// Reset clears valid bits and the running sum, not the basis table.
// ----------------------------------------------------------------------------
module sparse_edge_weight_gradient_core #(
  parameter int NUM_BASIS = sewg_pkg::NUM_BASIS_DEF,
  parameter int NUM_TYPES = sewg_pkg::NUM_TYPES_DEF,
  parameter int EDGE_BITS = sewg_pkg::EDGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // edge_index[19:0] syn_type[27:20] receptor[29:28] basis_value[45:30]
  // grad_0[61:46] grad_1[77:62] grad_2[93:78] grad_3[109:94]
  // activity[125:110], zero pad [127:126]
  input  logic [sewg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,   // kind
  input  logic                                in_tlast,   // last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // edge_out[19:0] grad_total[51:20], zero pad [55:52]
  output logic [sewg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser   // saturated
);

  localparam int NL        = (NUM_BASIS < sewg_pkg::LANES_MAX) ? NUM_BASIS
                                                              : sewg_pkg::LANES_MAX;
  localparam int TYPE_BITS = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam logic [63:0] EMASK_FULL = (64'd1 << EDGE_BITS) - 64'd1;
  localparam logic [sewg_pkg::EDGE_W-1:0] EDGE_MASK = EMASK_FULL[sewg_pkg::EDGE_W-1:0];
  localparam int OW = 49;
  localparam logic signed [OW-1:0] OUT_MAX = OW'(signed'(64'sd2147483647));
  localparam logic signed [OW-1:0] OUT_MIN = OW'(signed'(-64'sd2147483648));

  logic                                en;
  logic                                accepted;
  logic                                load_acc;
  logic                                samp_acc;
  logic [sewg_pkg::TYPE_W-1:0]         syn_type;
  logic [sewg_pkg::REC_W-1:0]          receptor;
  logic                                type_ok;
  logic [TYPE_BITS-1:0]                addr;
  sewg_pkg::tag_t                      tag_in;
  sewg_pkg::tag_t                      tag1_r;
  sewg_pkg::tag_t                      tag2_r;
  logic signed [sewg_pkg::PROD_W-1:0]  prod [NL];
  sewg_pkg::fin_t                      fin;
  logic signed [OW-1:0]                out_rnd;
  logic signed [OW-1:0]                out_q;
  logic [sewg_pkg::WG_W-1:0]           wg_nxt;
  logic                                osat_nxt;
  logic                                out_valid_r;
  logic [sewg_pkg::OUT_TDATA_W-1:0]    out_data_r;
  logic                                out_user_r;

  // pipeline advances unless a result sits unread in the output register
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accepted  = in_tvalid && en;
  assign load_acc  = accepted && (in_tuser == sewg_pkg::KIND_LOAD);
  assign samp_acc  = accepted && (in_tuser == sewg_pkg::KIND_SAMPLE);

  assign syn_type = in_tdata[sewg_pkg::TYPE_LSB +: sewg_pkg::TYPE_W];
  assign receptor = in_tdata[sewg_pkg::REC_LSB +: sewg_pkg::REC_W];
  assign type_ok  = {1'b0, syn_type} < 9'(NUM_TYPES);
  assign addr     = syn_type[TYPE_BITS-1:0];

  always_comb begin
    tag_in          = '0;
    tag_in.valid    = samp_acc;
    tag_in.last     = in_tlast;
    tag_in.edge_idx = in_tdata[sewg_pkg::EDGE_LSB +: sewg_pkg::EDGE_W] & EDGE_MASK;
    tag_in.act      = in_tdata[sewg_pkg::ACT_LSB +: sewg_pkg::VAL_W];
    tag_in.type_ok  = type_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (en) begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    sewg_lane #(
      .NUM_TYPES (NUM_TYPES),
      .TYPE_BITS (TYPE_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .wr_en (load_acc && type_ok && (receptor == sewg_pkg::REC_W'(i))),
      .addr  (addr),
      .wdata (in_tdata[sewg_pkg::BASIS_LSB +: sewg_pkg::VAL_W]),
      .grad  (in_tdata[sewg_pkg::GRAD_LSB + sewg_pkg::VAL_W*i +: sewg_pkg::VAL_W]),
      .ok    (tag1_r.type_ok),
      .prod  (prod[i])
    );
  end

  sewg_merge #(
    .NUM_LANES (NL)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .prod   (prod),
    .tag_in (tag2_r),
    .fin    (fin)
  );

  // final sum to Q.12, clamp to 32 bits
  always_comb begin
    out_rnd  = OW'(fin.acc) + OW'(signed'(64'sd2048));
    out_q    = out_rnd >>> 12;
    osat_nxt = 1'b0;
    if (out_q > OUT_MAX) begin
      wg_nxt   = {1'b0, {(sewg_pkg::WG_W-1){1'b1}}};
      osat_nxt = 1'b1;
    end else if (out_q < OUT_MIN) begin
      wg_nxt   = {1'b1, {(sewg_pkg::WG_W-1){1'b0}}};
      osat_nxt = 1'b1;
    end else begin
      wg_nxt = out_q[sewg_pkg::WG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin.valid) begin
      out_data_r <= {4'b0, wg_nxt, fin.edge_idx};
      out_user_r <= fin.sat | osat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
